// ===== hdl/lcd4_pkg.sv =====
// lcd4_pkg: shared types, request codes and the init command rom
// for the 4-bit character lcd interface; no dependencies
package lcd4_pkg;

  // request kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CMD   = 2'd1;
  localparam logic [1:0] KIND_SHIFT = 2'd2;
  localparam logic [1:0] KIND_INIT  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_SETUP   = 2'd0;
  localparam logic [1:0] CFG_PULSE   = 2'd1;
  localparam logic [1:0] CFG_DIVIDER = 2'd2;

  // reset values of the timing registers
  localparam logic [15:0] SETUP_RESET   = 16'd16;
  localparam logic [15:0] PULSE_RESET   = 16'd8;
  localparam logic [15:0] DIVIDER_RESET = 16'd500;

  // cursor shift command and its right-direction bit
  localparam logic [7:0] SHIFT_CMD       = 8'h10;
  localparam logic [7:0] SHIFT_RIGHT_BIT = 8'h04;

  // hardware limits on shift repeats and rom slots
  localparam int SHIFT_CAP = 32;
  localparam int ROM_SLOTS = 8;

  // timer request from the sequencer
  typedef struct packed {
    logic        start;
    logic [15:0] target;
  } tmr_ctrl_t;

  // one finished nibble strobe offered to the output register
  typedef struct packed {
    logic       valid;
    logic [3:0] nibble;
    logic       rs;
    logic       last;
  } emit_t;

  // init command rom
  function automatic logic [7:0] init_rom(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h02;
      3'd1:    b = 8'h28;
      3'd2:    b = 8'h0c;
      3'd3:    b = 8'h06;
      3'd4:    b = 8'h01;
      3'd5:    b = 8'h80;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/lcd4_if.sv =====
// lcd4_if: valid/ready channel interfaces for requests and nibble beats
// no dependencies
interface lcd4_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic [5:0] count;
  logic       direction;

  modport src (output valid, kind, value, count, direction, input ready);
  modport snk (input valid, kind, value, count, direction, output ready);
endinterface

interface lcd4_nib_if;
  logic       valid;
  logic       ready;
  logic [3:0] nibble;
  logic       register_select;
  logic       last;

  modport src (output valid, nibble, register_select, last, input ready);
  modport snk (input valid, nibble, register_select, last, output ready);
endinterface

// ===== hdl/lcd_4bit_nibble_interface.sv =====
// lcd_4bit_nibble_interface: top level, timing registers, sequencer, timer, output register
// each nibble is timed on the tick timer, a setup interval and then a pulse interval
// requests are taken only while idle; an item sends two nibbles per byte, up to 64 nibbles;
// a zero-count shift sends nothing; a finished nibble waits until the output register is free
// output register lets the next nibble be timed while a beat waits to be taken
// reset: asynchronous active low; timing registers return to 16, 8 and 500, sequencer to idle
module lcd_4bit_nibble_interface #(
  parameter int MAX_SHIFT   = 32,
  parameter int INIT_LENGTH = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lcd4_req_if.snk     req,
  lcd4_nib_if.src     nib,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import lcd4_pkg::*;

  logic [15:0] setup_q, pulse_q, divider_q;
  tmr_ctrl_t   tmr_w;
  logic        tmr_done_w;
  emit_t       emit_w;
  logic        emit_ready_w;
  logic        out_valid_q;
  logic [3:0]  out_nibble_q;
  logic        out_rs_q;
  logic        out_last_q;

  // timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_q   <= SETUP_RESET;
      pulse_q   <= PULSE_RESET;
      divider_q <= DIVIDER_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SETUP:   setup_q   <= cfg_data_i;
        CFG_PULSE:   pulse_q   <= cfg_data_i;
        CFG_DIVIDER: divider_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // shared tick timer
  lcd4_timer u_timer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .divider_i (divider_q),
    .ctrl_i    (tmr_w),
    .done_o    (tmr_done_w)
  );

  // request sequencer
  lcd4_seq #(
    .MAX_SHIFT   (MAX_SHIFT),
    .INIT_LENGTH (INIT_LENGTH)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req           (req),
    .setup_ticks_i (setup_q),
    .pulse_ticks_i (pulse_q),
    .tmr_o         (tmr_w),
    .tmr_done_i    (tmr_done_w),
    .emit_o        (emit_w),
    .emit_ready_i  (emit_ready_w)
  );

  // output register, loads when empty or when its beat is taken
  assign emit_ready_w = !out_valid_q || nib.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_ready_w) begin
      out_valid_q <= emit_w.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ready_w && emit_w.valid) begin
      out_nibble_q <= emit_w.nibble;
      out_rs_q     <= emit_w.rs;
      out_last_q   <= emit_w.last;
    end
  end

  assign nib.valid           = out_valid_q;
  assign nib.nibble          = out_nibble_q;
  assign nib.register_select = out_rs_q;
  assign nib.last            = out_last_q;

endmodule

// ===== hdl/lcd4_timer.sv =====
// lcd4_timer: shared tick timer, clock divider plus tick counter
// depends on lcd4_pkg
module lcd4_timer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        divider_i,
  input  lcd4_pkg::tmr_ctrl_t ctrl_i,
  output logic               done_o
);
  import lcd4_pkg::*;

  logic        busy_q, busy_d;
  logic [15:0] div_q, div_d;
  logic [15:0] tick_q, tick_d;
  logic [15:0] target_q, target_d;
  logic        tick_w, end_w;

  // a tick ends when the divider wraps, the interval when the tick count reaches target
  assign tick_w = busy_q && ({1'b0, div_q} + 17'd1 >= {1'b0, divider_i});
  assign end_w  = tick_w && ({1'b0, tick_q} + 17'd1 >= {1'b0, target_q});
  assign done_o = end_w;

  // next state of the counters
  always_comb begin
    busy_d   = busy_q;
    div_d    = div_q;
    tick_d   = tick_q;
    target_d = target_q;
    if (ctrl_i.start) begin
      busy_d   = 1'b1;
      div_d    = '0;
      tick_d   = '0;
      target_d = ctrl_i.target;
    end else if (busy_q) begin
      if (tick_w) begin
        div_d = '0;
        if (end_w) begin
          busy_d = 1'b0;
          tick_d = '0;
        end else begin
          tick_d = tick_q + 16'd1;
        end
      end else begin
        div_d = div_q + 16'd1;
      end
    end
  end

  // counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      div_q    <= '0;
      tick_q   <= '0;
      target_q <= '0;
    end else begin
      busy_q   <= busy_d;
      div_q    <= div_d;
      tick_q   <= tick_d;
      target_q <= target_d;
    end
  end

endmodule

// ===== hdl/lcd4_seq.sv =====
// lcd4_seq: request sequencer, walks bytes and nibbles and drives the shared timer
// depends on lcd4_pkg and lcd4_if
module lcd4_seq #(
  parameter int MAX_SHIFT   = 32,
  parameter int INIT_LENGTH = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  lcd4_req_if.snk             req,
  input  logic [15:0]         setup_ticks_i,
  input  logic [15:0]         pulse_ticks_i,
  output lcd4_pkg::tmr_ctrl_t tmr_o,
  input  logic                tmr_done_i,
  output lcd4_pkg::emit_t     emit_o,
  input  logic                emit_ready_i
);
  import lcd4_pkg::*;

  // repeat limits from parameters
  localparam int          CAP_I   = (MAX_SHIFT < SHIFT_CAP) ? MAX_SHIFT : SHIFT_CAP;
  localparam logic [5:0]  CAP     = 6'(CAP_I);
  localparam int          LEN_HI  = (INIT_LENGTH > ROM_SLOTS) ? ROM_SLOTS : INIT_LENGTH;
  localparam int          LEN_I   = (LEN_HI < 1) ? 1 : LEN_HI;
  localparam logic [5:0]  INIT_LEFT = 6'(LEN_I - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ARM    = 3'd1;
  localparam logic [2:0] ST_WSETUP = 3'd2;
  localparam logic [2:0] ST_WPULSE = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0] state_q, state_d;
  logic [7:0] byte_q, byte_d;
  logic       rs_q, rs_d;
  logic       hi_q, hi_d;
  logic [5:0] left_q, left_d;
  logic [2:0] init_q, init_d;
  logic       is_init_q, is_init_d;
  logic [5:0] cnt_w;

  // saturated shift count
  assign cnt_w = (req.count > CAP) ? CAP : req.count;

  // sequencer next state
  always_comb begin
    state_d   = state_q;
    byte_d    = byte_q;
    rs_d      = rs_q;
    hi_d      = hi_q;
    left_d    = left_q;
    init_d    = init_q;
    is_init_d = is_init_q;
    req.ready = 1'b0;
    tmr_o     = '0;
    emit_o.valid  = 1'b0;
    emit_o.nibble = hi_q ? byte_q[7:4] : byte_q[3:0];
    emit_o.rs     = rs_q;
    emit_o.last   = !hi_q && (left_q == '0);
    unique case (state_q)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          hi_d      = 1'b1;
          init_d    = '0;
          is_init_d = 1'b0;
          left_d    = '0;
          state_d   = ST_ARM;
          unique case (req.kind)
            KIND_DATA: begin
              byte_d = req.value;
              rs_d   = 1'b1;
            end
            KIND_CMD: begin
              byte_d = req.value;
              rs_d   = 1'b0;
            end
            KIND_SHIFT: begin
              byte_d = SHIFT_CMD | (req.direction ? SHIFT_RIGHT_BIT : 8'h00);
              rs_d   = 1'b0;
              left_d = cnt_w - 6'd1;
              // a zero count sends nothing
              if (cnt_w == '0) begin
                state_d = ST_IDLE;
                left_d  = '0;
              end
            end
            default: begin
              byte_d    = init_rom(3'd0);
              rs_d      = 1'b0;
              left_d    = INIT_LEFT;
              is_init_d = 1'b1;
            end
          endcase
        end
      end
      ST_ARM: begin
        tmr_o.start  = 1'b1;
        tmr_o.target = setup_ticks_i;
        state_d      = ST_WSETUP;
      end
      ST_WSETUP: begin
        if (tmr_done_i) begin
          tmr_o.start  = 1'b1;
          tmr_o.target = pulse_ticks_i;
          state_d      = ST_WPULSE;
        end
      end
      ST_WPULSE: begin
        if (tmr_done_i) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        emit_o.valid = 1'b1;
        if (emit_ready_i) begin
          if (hi_q) begin
            hi_d    = 1'b0;
            state_d = ST_ARM;
          end else if (left_q == '0) begin
            init_d    = '0;
            is_init_d = 1'b0;
            state_d   = ST_IDLE;
          end else begin
            left_d  = left_q - 6'd1;
            init_d  = init_q + 3'd1;
            byte_d  = is_init_q ? init_rom(init_q + 3'd1) : byte_q;
            hi_d    = 1'b1;
            state_d = ST_ARM;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      byte_q    <= '0;
      rs_q      <= 1'b0;
      hi_q      <= 1'b1;
      left_q    <= '0;
      init_q    <= '0;
      is_init_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      byte_q    <= byte_d;
      rs_q      <= rs_d;
      hi_q      <= hi_d;
      left_q    <= left_d;
      init_q    <= init_d;
      is_init_q <= is_init_d;
    end
  end

endmodule

// ===== sim/tb_lcd_4bit_nibble_interface.sv =====
// tb_lcd_4bit_nibble_interface: self-checking testbench for the 4-bit lcd nibble interface
// depends on hdl/lcd4_pkg.sv, hdl/lcd4_if.sv and hdl/lcd_4bit_nibble_interface.sv
// requests are expanded into expected nibble beats and compared in order with the output
`timescale 1ns / 100ps

module tb_lcd_4bit_nibble_interface;
  import lcd4_pkg::*;

  localparam int MAX_SHIFT_P   = 32;
  localparam int INIT_LENGTH_P = 6;
  localparam logic [1:0] CFG_NONE = 2'd3;  // unused register index, writes are dropped
  localparam longint WATCHDOG_LIMIT = 600000;

  // power-up command list of the display, padded to the full rom size
  localparam logic [7:0] POWER_UP_CMDS [8] = '{8'h02, 8'h28, 8'h0c, 8'h06,
                                               8'h01, 8'h80, 8'h00, 8'h00};

  typedef struct packed {
    logic [3:0] nibble;
    logic       rs;
    logic       last;
  } nib_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_data;

  lcd4_req_if req_ch ();
  lcd4_nib_if nib_ch ();

  lcd_4bit_nibble_interface #(
    .MAX_SHIFT   (MAX_SHIFT_P),
    .INIT_LENGTH (INIT_LENGTH_P)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_ch),
    .nib        (nib_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // expected beats, oldest first
  nib_beat_t pending_nibbles [$];

  // timing register copy
  logic [15:0] setup_copy   = SETUP_RESET;
  logic [15:0] pulse_copy   = PULSE_RESET;
  logic [15:0] divider_copy = DIVIDER_RESET;

  bit     idle_en = 1'b1;
  int     fail_count;
  int     requests_sent;
  int     beats_seen;
  int     timing_sets;
  int     stall_left;
  longint quiet_cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // expected beats of one byte, high nibble first
  function automatic void queue_byte(input logic [7:0] b, input logic rs, input logic final_byte);
    pending_nibbles.push_back('{nibble: b[7:4], rs: rs, last: 1'b0});
    pending_nibbles.push_back('{nibble: b[3:0], rs: rs, last: final_byte});
  endfunction

  // expand one request into the beats the display bus should see
  function automatic void expand_request(input logic [1:0] kind, input logic [7:0] value,
                                         input logic [5:0] count, input logic dir);
    int         reps;
    int         len;
    logic [7:0] shift_cmd;
    case (kind)
      KIND_DATA: queue_byte(value, 1'b1, 1'b1);
      KIND_CMD:  queue_byte(value, 1'b0, 1'b1);
      KIND_SHIFT: begin
        reps = count;
        if (reps > MAX_SHIFT_P) reps = MAX_SHIFT_P;
        if (reps > SHIFT_CAP) reps = SHIFT_CAP;
        shift_cmd = SHIFT_CMD | (dir ? SHIFT_RIGHT_BIT : 8'h00);
        for (int i = 0; i < reps; i++) queue_byte(shift_cmd, 1'b0, i == reps - 1);
      end
      default: begin
        len = INIT_LENGTH_P;
        if (len > ROM_SLOTS) len = ROM_SLOTS;
        if (len < 1) len = 1;
        for (int i = 0; i < len; i++) queue_byte(POWER_UP_CMDS[i], 1'b0, i == len - 1);
      end
    endcase
  endfunction

  // cycles one nibble takes under the current timing
  function automatic longint nibble_cycles();
    return 2 + (longint'(setup_copy) + longint'(pulse_copy)) * longint'(divider_copy);
  endfunction

  // receiver stalls in random bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nib_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      nib_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      nib_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(1, 13) - 1;
    end else begin
      nib_ch.ready <= 1'b1;
    end
  end

  // compare each output beat with the oldest expectation
  always @(posedge clk_i) begin
    nib_beat_t want;
    if (rst_ni && nib_ch.valid && nib_ch.ready) begin
      beats_seen++;
      if (pending_nibbles.size() == 0) begin
        $error("unexpected beat: nibble %h rs %b last %b",
               nib_ch.nibble, nib_ch.register_select, nib_ch.last);
        fail_count++;
      end else begin
        want = pending_nibbles.pop_front();
        if (nib_ch.nibble !== want.nibble) begin
          $error("nibble: expected %h, actual %h", want.nibble, nib_ch.nibble);
          fail_count++;
        end
        if (nib_ch.register_select !== want.rs) begin
          $error("register_select: expected %b, actual %b", want.rs, nib_ch.register_select);
          fail_count++;
        end
        if (nib_ch.last !== want.last) begin
          $error("last: expected %b, actual %b", want.last, nib_ch.last);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (nib_ch.valid && nib_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d beats still expected", pending_nibbles.size());
      $display("tb_lcd_4bit_nibble_interface NOT OK");
      $finish;
    end
  end

  // one request beat, with an optional gap before it
  task automatic send_request(input logic [1:0] kind, input logic [7:0] value,
                              input logic [5:0] count, input logic dir);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.kind      <= kind;
    req_ch.value     <= value;
    req_ch.count     <= count;
    req_ch.direction <= dir;
    do @(posedge clk_i); while (!req_ch.ready);
    expand_request(kind, value, count, dir);
    requests_sent++;
  endtask

  // random request, mostly data and commands with short counts, init now and then
  task automatic send_random_request();
    int         pick;
    logic [1:0] kind;
    logic [5:0] count;
    pick = $urandom_range(0, 15);
    if (pick <= 5) kind = KIND_DATA;
    else if (pick <= 10) kind = KIND_CMD;
    else if (pick <= 14) kind = KIND_SHIFT;
    else kind = KIND_INIT;
    count = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 6));
    send_request(kind, 8'($urandom), count, 1'($urandom));
  endtask

  // stop sending, wait for every expected beat, then let the sequencer settle
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_nibbles.size() != 0) @(posedge clk_i);
    repeat (nibble_cycles() + 4) @(posedge clk_i);
  endtask

  // write all timing registers back to back, plus one write to an unused index
  task automatic set_timing(input logic [15:0] setup, input logic [15:0] pulse,
                            input logic [15:0] divider);
    logic [1:0]  idx  [4];
    logic [15:0] data [4];
    idx  = '{CFG_SETUP, CFG_PULSE, CFG_DIVIDER, CFG_NONE};
    data = '{setup, pulse, divider, 16'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idx[i];
      cfg_data <= data[i];
      @(posedge clk_i);
      case (idx[i])
        CFG_SETUP:   setup_copy   = data[i];
        CFG_PULSE:   pulse_copy   = data[i];
        CFG_DIVIDER: divider_copy = data[i];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
    timing_sets++;
  endtask

  // one data byte with the timing left at its reset values
  task automatic test_reset_timing();
    send_request(KIND_DATA, 8'h4b, 6'd0, 1'b0);
    drain();
  endtask

  // field extremes, every request kind, zero and saturated shift counts
  task automatic test_directed();
    set_timing(16'd1, 16'd1, 16'd1);
    send_request(KIND_DATA,  8'h00, 6'd63, 1'b1);
    send_request(KIND_DATA,  8'hff, 6'd0,  1'b0);
    send_request(KIND_DATA,  8'ha5, 6'd21, 1'b1);
    send_request(KIND_CMD,   8'h00, 6'd42, 1'b0);
    send_request(KIND_CMD,   8'hff, 6'd0,  1'b1);
    send_request(KIND_CMD,   8'h5a, 6'd63, 1'b0);
    send_request(KIND_SHIFT, 8'hff, 6'd0,  1'b0);
    send_request(KIND_SHIFT, 8'h00, 6'd1,  1'b0);
    send_request(KIND_SHIFT, 8'h00, 6'd1,  1'b1);
    send_request(KIND_SHIFT, 8'h3c, 6'd0,  1'b1);
    send_request(KIND_SHIFT, 8'h00, 6'd31, 1'b0);
    send_request(KIND_SHIFT, 8'hff, 6'd32, 1'b1);
    send_request(KIND_SHIFT, 8'h00, 6'd33, 1'b0);
    send_request(KIND_SHIFT, 8'h81, 6'd63, 1'b1);
    send_request(KIND_INIT,  8'h00, 6'd0,  1'b0);
    send_request(KIND_INIT,  8'hff, 6'd63, 1'b1);
    send_request(KIND_SHIFT, 8'h00, 6'd0,  1'b1);
    drain();
  endtask

  // each timing register at its upper limit, the others at one
  task automatic test_timing_extremes();
    set_timing(16'hffff, 16'd1, 16'd1);
    send_request(KIND_DATA, 8'h5a, 6'd0, 1'b0);
    drain();
    set_timing(16'd1, 16'hffff, 16'd1);
    send_request(KIND_CMD, 8'hc3, 6'd0, 1'b0);
    drain();
    set_timing(16'd1, 16'd1, 16'hffff);
    send_request(KIND_DATA, 8'h96, 6'd0, 1'b0);
    drain();
  endtask

  // random requests in phases, full drain and new timing between phases
  task automatic test_random();
    for (int p = 0; p < 4; p++) begin
      set_timing(16'($urandom_range(1, 3)), 16'($urandom_range(1, 3)),
                 16'($urandom_range(1, 2)));
      repeat (20) send_random_request();
      drain();
    end
  endtask

  // back-to-back traffic with neither side idling
  task automatic test_no_idle();
    idle_en = 1'b0;
    set_timing(16'd1, 16'd1, 16'd1);
    repeat (20) send_random_request();
    drain();
  endtask

  // sequence of tests
  initial begin
    rst_ni           = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.kind      = KIND_DATA;
    req_ch.value     = 8'h00;
    req_ch.count     = 6'd0;
    req_ch.direction = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_SETUP;
    cfg_data         = 16'd0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_timing();
    test_directed();
    test_timing_extremes();
    test_random();
    test_no_idle();

    $display("run covered %0d requests and %0d nibble beats over %0d timing settings",
             requests_sent, beats_seen, timing_sets + 1);
    $display("all request kinds, zero and saturated shifts, register limits, idle and busy bus");
    if (fail_count == 0) begin
      $display("tb_lcd_4bit_nibble_interface OK");
    end else begin
      $display("tb_lcd_4bit_nibble_interface NOT OK");
    end
    $finish;
  end

endmodule
